// ===== rtl/spl_pkg.sv =====
// Package for the stereo peak limiter: payload structs, gain constants, register indices.
// No dependencies.
`default_nettype none
package spl_pkg;
  localparam int unsigned GainW = 25;
  localparam logic [24:0] GainOne = 25'd16777216;
  localparam logic [24:0] SmoothCoeff = 25'd1677722;

  typedef struct packed {
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
  } out_t;

  typedef enum logic [2:0] {
    RegInvThr  = 3'd0,
    RegOutGain = 3'd1,
    RegAttack  = 3'd2,
    RegRelease = 3'd3,
    RegHold    = 3'd4
  } reg_idx_e;
endpackage
`default_nettype wire

// ===== rtl/spl_cell.sv =====
// One window cell: a delay stage of 2**IDX entries that swaps in a gain and keeps the min.
// Depends on nothing.
`default_nettype none
module spl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 9
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [PW-1:0] pos_i,
  input  wire logic [24:0] g_i,
  output logic [24:0]      g_o
);
  localparam int unsigned D  = 1 << IDX;
  localparam int unsigned AW = (IDX == 0) ? 1 : IDX;

  logic [24:0] mem_q [D];
  logic [24:0] rd_q;
  logic        full_q;
  logic [AW-1:0] addr;
  logic        last;
  logic [24:0] old;

  if (IDX == 0) begin : g_a0
    logic unused;
    assign addr   = 1'b0;
    assign last   = 1'b1;
    assign unused = ^pos_i;
  end else begin : g_an
    assign addr = pos_i[AW-1:0];
    assign last = &pos_i[AW-1:0];
  end

  // every entry holds a gain once the address has come round once
  assign old = full_q ? rd_q : '0;
  assign g_o = (old < g_i) ? old : g_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (step_i && last) begin
      full_q <= 1'b1;
    end
  end

  // address holds for the whole walk, so the registered read is ready at the step
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      mem_q[addr] <= g_i;
    end
    rd_q <= mem_q[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/spl_div.sv =====
// Serial restoring divider: quotient of 2**63 by a 64-bit denominator, one bit per cycle.
// Depends on nothing.
`default_nettype none
module spl_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [24:0]      quo_o
);
  logic [64:0] rem_q;
  logic [63:0] den_q;
  logic [24:0] quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [64:0] sh;
  logic [65:0] diff;

  // quotient < 2**24 since den > 2**39; long division from bit 24 downward
  assign sh   = rem_q << 1;
  assign diff = {1'b0, sh} - {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd25;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= {1'b0, 64'h0000_0000_4000_0000} << 8; // 2**38, first shift yields 2**39
      quo_q <= '0;
    end else if (busy_q) begin
      if (!diff[65]) begin
        rem_q <= diff[64:0];
        quo_q <= {quo_q[23:0], 1'b1};
      end else begin
        rem_q <= sh;
        quo_q <= {quo_q[23:0], 1'b0};
      end
    end
  end
  assign quo_o = quo_q;
endmodule
`default_nettype wire

// ===== rtl/stereo_peak_limiter_min_hold_core.sv =====
// Top level of the stereo peak limiter with min-hold window, smoothers and envelope.
// Depends on spl_pkg, spl_cell, spl_div.
//
//   channel | signals                      | direction
//   in      | in_valid_i in_ready_o in_i   | sample pair in
//   out     | out_valid_o out_ready_i out_o| limited pair out
//   cfg     | cfg_we_i cfg_idx_i cfg_data_i| register writes
//
// A pair whose peak is above unity passes from its transfer to a valid result through
// these steps in order: scaling the peak, the serial divider (one quotient bit a cycle,
// then the done strobe), the walk along the cell chain, four smoother updates, one
// envelope update, four output multiplies, and raising valid.
// A peak at most unity skips the divider.
// Reset clears the window fill flags, smoothers, envelope and hold count.
// A new pair is taken only when the previous result has left the output register.
`default_nettype none
module stereo_peak_limiter_min_hold_core #(
  parameter int unsigned WINDOW_STAGES = 9
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire spl_pkg::in_t  in_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output spl_pkg::out_t      out_o,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [30:0]   cfg_data_i
);
  localparam int unsigned PW = WINDOW_STAGES;
  localparam int unsigned CW = $clog2(WINDOW_STAGES + 1);
  localparam logic signed [24:0] Limit = 25'sd8387769;

  typedef enum logic [2:0] {
    SIdle, SMul, SDiv, SWalk, SSmooth, SEnv, SOut, SDone
  } state_e;

  // configuration registers
  logic [30:0] inv_thr_q, out_gain_q;
  logic [24:0] att_q, rel_q;
  logic [16:0] hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_thr_q  <= 31'd65536;
      out_gain_q <= 31'd65536;
      att_q      <= 25'd785841;
      rel_q      <= 25'd10727;
      hold_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spl_pkg::RegInvThr:  inv_thr_q  <= cfg_data_i;
        spl_pkg::RegOutGain: out_gain_q <= cfg_data_i;
        spl_pkg::RegAttack:  att_q      <= cfg_data_i[24:0];
        spl_pkg::RegRelease: rel_q      <= cfg_data_i[24:0];
        spl_pkg::RegHold:    hold_q     <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  state_e state_q;
  spl_pkg::in_t smp_q;
  logic [24:0] g_q;
  logic [CW-1:0] stage_q;
  logic [PW-1:0] pos_q;
  logic [24:0] sm_q [4];
  logic [2:0]  sidx_q;
  logic [24:0] env_q;
  logic [16:0] cnt_q;
  logic        ch_q, part_q;
  logic signed [49:0] t_q;
  logic signed [23:0] lo_q;

  // peak magnitude
  logic [23:0] al, ar, pk;
  assign al = smp_q.left_sample[23]  ? 24'(-smp_q.left_sample)  : smp_q.left_sample;
  assign ar = smp_q.right_sample[23] ? 24'(-smp_q.right_sample) : smp_q.right_sample;
  assign pk = (al > ar) ? al : ar;

  // scaled peak, read in SMul while smp_q holds the accepted pair
  logic [54:0] scaled;
  assign scaled = 55'(pk) * 55'(inv_thr_q);

  // divider
  logic div_start, div_done;
  logic [24:0] quo;
  assign div_start = (state_q == SMul) && (scaled > (55'd1 << 39));
  spl_div u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .den_i({9'd0, scaled}), .done_o(div_done), .quo_o(quo)
  );

  // cell chain: walk one cell a cycle
  logic [24:0] cell_g [WINDOW_STAGES];
  for (genvar j = 0; j < WINDOW_STAGES; j++) begin : g_cell
    logic step;
    assign step = (state_q == SWalk) && (stage_q == CW'(j));
    spl_cell #(.IDX(j), .PW(PW)) u_cell (
      .clk_i, .rst_ni, .step_i(step), .pos_i(pos_q),
      .g_i(g_q), .g_o(cell_g[j])
    );
  end
  logic [24:0] walk_g;
  always_comb begin
    walk_g = g_q;
    for (int k = 0; k < WINDOW_STAGES; k++) begin
      if (stage_q == CW'(k)) walk_g = cell_g[k];
    end
  end

  // shared one-pole update: s + round((t - s) * c / 2**24), clamped
  logic [24:0] sm_s, sm_t, sm_c, sm_n;
  logic signed [25:0] sm_d;
  logic [25:0] sm_mag;
  logic [50:0] sm_p;
  logic [26:0] sm_r;
  logic signed [26:0] sm_sum;
  assign sm_d   = $signed({1'b0, sm_t}) - $signed({1'b0, sm_s});
  assign sm_mag = sm_d[25] ? 26'(-sm_d) : 26'(sm_d);
  assign sm_p   = 51'(sm_mag) * 51'(sm_c);
  assign sm_r   = 27'((sm_p + (51'd1 << 23)) >> 24);
  assign sm_sum = sm_d[25] ? $signed({2'b0, sm_s}) - $signed(sm_r)
                           : $signed({2'b0, sm_s}) + $signed(sm_r);
  assign sm_n = (sm_sum < 0) ? '0 :
                (sm_sum > $signed({2'b0, spl_pkg::GainOne})) ? spl_pkg::GainOne
                                                            : sm_sum[24:0];

  logic env_attack;
  assign env_attack = env_q > sm_q[3];

  always_comb begin
    sm_s = sm_q[0];
    sm_t = g_q;
    sm_c = spl_pkg::SmoothCoeff;
    if (state_q == SEnv) begin
      sm_s = env_q;
      sm_t = sm_q[3];
      sm_c = env_attack ? ((att_q > spl_pkg::GainOne) ? spl_pkg::GainOne : att_q)
                        : ((rel_q > spl_pkg::GainOne) ? spl_pkg::GainOne : rel_q);
    end else begin
      case (sidx_q)
        3'd1: begin sm_s = sm_q[1]; sm_t = sm_q[0]; end
        3'd2: begin sm_s = sm_q[2]; sm_t = sm_q[1]; end
        3'd3: begin sm_s = sm_q[3]; sm_t = sm_q[2]; end
        default: ;
      endcase
    end
  end

  // output shaping, two multiplies per channel, registered between
  logic signed [23:0] x;
  assign x = ch_q ? smp_q.right_sample : smp_q.left_sample;
  logic [23:0] xm;
  assign xm = x[23] ? 24'(-x) : x;
  logic [48:0] p1;
  assign p1 = 49'(xm) * 49'(env_q);
  logic [24:0] t1;
  assign t1 = 25'((p1 + (49'd1 << 23)) >> 24);
  logic [24:0] tm;
  assign tm = t_q[49] ? 25'(-t_q) : t_q[24:0];
  logic [55:0] p2;
  assign p2 = 56'(tm) * 56'(out_gain_q);
  logic [40:0] y;
  assign y = 41'((p2 + 56'd32768) >> 16);
  logic signed [23:0] ys;
  assign ys = (y > 41'(Limit)) ? (t_q[49] ? -Limit[23:0] : Limit[23:0])
                               : (t_q[49] ? 24'(-y[23:0]) : y[23:0]);

  assign in_ready_o = (state_q == SIdle) && !out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_o <= 1'b0;
      stage_q     <= '0;
      pos_q       <= '0;
      sidx_q      <= '0;
      env_q       <= '0;
      cnt_q       <= '0;
      ch_q        <= 1'b0;
      part_q      <= 1'b0;
      for (int i = 0; i < 4; i++) sm_q[i] <= '0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        SIdle: if (in_valid_i && in_ready_o) state_q <= SMul;
        SMul: begin
          // skip the divider when the peak is at most unity
          if (!div_start) begin
            state_q <= SWalk;
            stage_q <= '0;
          end else begin
            state_q <= SDiv;
          end
        end
        SDiv: if (div_done) begin
          state_q <= SWalk;
          stage_q <= '0;
        end
        SWalk: begin
          stage_q <= stage_q + CW'(1);
          if (stage_q == CW'(WINDOW_STAGES - 1)) begin
            state_q <= SSmooth;
            sidx_q  <= '0;
            pos_q   <= pos_q + PW'(1);
          end
        end
        SSmooth: begin
          sm_q[sidx_q[1:0]] <= sm_n;
          sidx_q <= sidx_q + 3'd1;
          if (sidx_q == 3'd3) state_q <= SEnv;
        end
        SEnv: begin
          if (env_attack) begin
            env_q <= sm_n;
            cnt_q <= (hold_q != 0) ? hold_q - 17'd1 : '0;
          end else begin
            if (cnt_q == 0) env_q <= sm_n;
            else cnt_q <= cnt_q - 17'd1;
          end
          state_q <= SOut;
          ch_q    <= 1'b0;
          part_q  <= 1'b0;
        end
        SOut: begin
          part_q <= !part_q;
          if (part_q) begin
            ch_q <= 1'b1;
            if (ch_q) state_q <= SDone;
          end
        end
        SDone: begin
          out_valid_o <= 1'b1;
          state_q     <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) smp_q <= in_i;
    if (state_q == SMul && !div_start) g_q <= spl_pkg::GainOne;
    if (state_q == SDiv && div_done) g_q <= quo;
    if (state_q == SWalk) g_q <= walk_g;
    if (state_q == SOut && !part_q) t_q <= x[23] ? -$signed({25'd0, t1}) : $signed({25'd0, t1});
    if (state_q == SOut && part_q) begin
      if (!ch_q) lo_q <= ys;
      else begin
        out_o.left_out  <= lo_q;
        out_o.right_out <= ys;
      end
    end
  end

  a_one_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone) |=> out_valid_o);
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_ready_o);
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= spl_pkg::GainOne);
endmodule
`default_nettype wire
